// File: hw/rtl/loa_pkg.sv
// ----------------------------------------------------------------------------
// loa_pkg
// Shared types and constants for the lane owner arbiter.
// ----------------------------------------------------------------------------
package loa_pkg;

  localparam int LANE_COUNT = 4;
  localparam int DONE_DEPTH = 64;
  localparam int LANE_W     = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int DONE_AW    = (DONE_DEPTH > 1) ? $clog2(DONE_DEPTH) : 1;
  localparam int DONE_CW    = $clog2(DONE_DEPTH + 1);
  localparam int OWNER_W    = 63;
  localparam int STAMP_W    = 32;
  localparam int QDEPTH     = 2;

  localparam logic [1:0] MODE_TRY     = 2'd0;
  localparam logic [1:0] MODE_MUST    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_MARK    = 2'd3;

  localparam logic [1:0] ST_IO    = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  // request word passed from front to back
  typedef struct packed {
    logic [1:0]         mode;
    logic [OWNER_W-1:0] owner;
  } req_t;

  // result word
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] lane;
    logic       lane_found;
    logic [1:0] oldest_lane;
    logic       oldest_valid;
    logic       processed_full;
  } res_t;

endpackage

// File: hw/rtl/lane_owner_arbiter_core.sv
// Lane owner arbiter: hands LANE_COUNT lanes to 63-bit owner IDs and keeps a
// store of up to DONE_DEPTH processed owners. For each request the back end
// picks up the word, reads the processed store one entry per cycle through its
// single read port, walks the lane table, updates, walks the lane table again
// and hands the result off. A two-word queue lets new requests be taken while
// one is in work, and the result register holds a finished word while the next
// request runs; a request ends only once the previous word has left that
// register.
// ----------------------------------------------------------------------------
// lane_owner_arbiter_core
// Top level: stream ports, passthrough register, front queue and back end.
// ----------------------------------------------------------------------------
module lane_owner_arbiter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_tuser,    // mode
  input  logic [63:0] in_tdata,   // [62:0] owner, [63] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_tuser,   // status
  output logic [7:0] out_tdata    // lane, lane_found, oldest_lane, oldest_valid,
                                  // processed_full, zero pad
);

  logic          pass_r;
  loa_pkg::req_t in_req, q_req;
  loa_pkg::res_t res;
  logic          q_valid, q_pop;

  // passthrough register
  always_ff @(posedge clk) begin
    if (!rst_n) pass_r <= 1'b0;
    else if (cfg_we) pass_r <= cfg_wdata;
  end

  assign in_req.mode  = in_tuser;
  assign in_req.owner = in_tdata[62:0];

  loa_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_req (in_req),
    .q_valid, .q_pop, .q_req
  );

  loa_back u_back (
    .clk, .rst_n, .passthrough (pass_r),
    .q_valid, .q_pop, .q_req,
    .res_valid (out_tvalid), .res_ready (out_tready), .res
  );

  assign out_tuser = res.status;
  assign out_tdata = {1'b0, res.processed_full, res.oldest_valid, res.oldest_lane,
                      res.lane_found, res.lane};

endmodule

// File: hw/rtl/loa_front.sv
// ----------------------------------------------------------------------------
// loa_front
// Accepts request words and queues them for the back end.
// ----------------------------------------------------------------------------
module loa_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  loa_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_pop,
  output loa_pkg::req_t q_req
);

  loa_pkg::req_t      mem_r [loa_pkg::QDEPTH];
  logic               wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push;

  assign in_ready = (cnt_r != 2'(loa_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_req;
    end
  end

endmodule

// File: hw/rtl/loa_back.sv
// ----------------------------------------------------------------------------
// loa_back
// Sequencer that runs one request: store scan, lane scan, update, oldest scan.
// ----------------------------------------------------------------------------
module loa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          passthrough,
  input  logic          q_valid,
  output logic          q_pop,
  input  loa_pkg::req_t q_req,
  output logic          res_valid,
  input  logic          res_ready,
  output loa_pkg::res_t res
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DSCN = 6'b000010,
    S_LSCN = 6'b000100,
    S_UPD  = 6'b001000,
    S_OLD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam int LIW = $clog2(loa_pkg::LANE_COUNT + 1);

  state_t state_r, state_nxt;

  logic [loa_pkg::LANE_COUNT-1:0] busy_r;
  logic [loa_pkg::OWNER_W-1:0]   holder_r [loa_pkg::LANE_COUNT];
  logic [loa_pkg::STAMP_W-1:0]   stamp_r  [loa_pkg::LANE_COUNT];
  logic [loa_pkg::STAMP_W-1:0]   next_stamp_r;
  logic [loa_pkg::OWNER_W-1:0]   done_mem [loa_pkg::DONE_DEPTH];
  logic [loa_pkg::OWNER_W-1:0]   done_rd_r;
  logic [loa_pkg::DONE_CW-1:0]   done_cnt_r;

  loa_pkg::req_t                 req_r;
  logic [loa_pkg::DONE_CW-1:0]   didx_r;      // next store entry to read
  logic                          rd_pend_r;   // done_rd_r holds entry didx_r-1
  logic                          is_done_r;
  logic [LIW-1:0]                lidx_r;
  logic                          held_r;
  logic [loa_pkg::LANE_W-1:0]    held_lane_r;
  logic                          free_ok_r;
  logic [loa_pkg::LANE_W-1:0]    free_lane_r;
  logic [loa_pkg::STAMP_W-1:0]   best_r;
  loa_pkg::res_t                 res_r;       // word being built
  loa_pkg::res_t                 out_r;       // word on the result port
  logic                          res_valid_r, res_valid_nxt;

  logic [loa_pkg::LANE_W-1:0]    li;
  logic                          do_write;
  logic                          hit;
  logic                          take_new;
  loa_pkg::res_t                 upd_res, old_res;

  assign li        = lidx_r[loa_pkg::LANE_W-1:0];
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign res_valid = res_valid_r;
  assign res       = out_r;
  assign hit       = rd_pend_r && (done_rd_r == req_r.owner);
  assign do_write  = (state_r == S_UPD) && (req_r.mode[1]) && !is_done_r && !hit
                     && (done_cnt_r < loa_pkg::DONE_CW'(loa_pkg::DONE_DEPTH));

  // store read port
  always_ff @(posedge clk) begin
    done_rd_r <= done_mem[didx_r[loa_pkg::DONE_AW-1:0]];
    if (do_write) begin
      done_mem[done_cnt_r[loa_pkg::DONE_AW-1:0]] <= req_r.owner;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_DSCN;
      S_DSCN: if ((hit || is_done_r) || (didx_r == done_cnt_r && !rd_pend_r))
                state_nxt = S_LSCN;
      S_LSCN: if (lidx_r == LIW'(loa_pkg::LANE_COUNT)) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_OLD;
      S_OLD:  if (lidx_r == LIW'(loa_pkg::LANE_COUNT)) state_nxt = S_OUT;
      S_OUT:  if (!res_valid_r || res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid: cleared on hand-off, set when a finished word moves out
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_valid_r && res_ready) res_valid_nxt = 1'b0;
    if (state_r == S_OUT && (!res_valid_r || res_ready)) res_valid_nxt = 1'b1;
  end

  // outcome of the update step
  always_comb begin
    upd_res  = '0;
    take_new = 1'b0;
    if (req_r.mode == loa_pkg::MODE_TRY && passthrough) begin
      upd_res.status = loa_pkg::ST_IO;
    end else if (req_r.mode == loa_pkg::MODE_TRY && is_done_r) begin
      upd_res.status = loa_pkg::ST_SKIP;
    end else if (!req_r.mode[1]) begin
      if (held_r) begin
        upd_res.status     = loa_pkg::ST_IO;
        upd_res.lane       = 2'(held_lane_r);
        upd_res.lane_found = 1'b1;
      end else if (free_ok_r) begin
        take_new           = 1'b1;
        upd_res.status     = (req_r.mode == loa_pkg::MODE_TRY) ?
                             loa_pkg::ST_PROBE : loa_pkg::ST_IO;
        upd_res.lane       = 2'(free_lane_r);
        upd_res.lane_found = 1'b1;
      end else begin
        upd_res.status = loa_pkg::ST_BUSY;
      end
    end else begin
      upd_res.processed_full = !is_done_r && !hit &&
        (done_cnt_r >= loa_pkg::DONE_CW'(loa_pkg::DONE_DEPTH));
    end
  end

  // oldest-lane candidate at the current scan position
  always_comb begin
    old_res = res_r;
    if (lidx_r != LIW'(loa_pkg::LANE_COUNT) && busy_r[li] &&
        (!res_r.oldest_valid || stamp_r[li] < best_r)) begin
      old_res.oldest_lane  = 2'(li);
      old_res.oldest_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= '0;
      next_stamp_r <= '0;
      done_cnt_r   <= '0;
      res_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      didx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      if (do_write) done_cnt_r <= done_cnt_r + loa_pkg::DONE_CW'(1);
      case (state_r)
        S_IDLE: begin
          didx_r    <= '0;
          rd_pend_r <= 1'b0;
          if (q_valid) begin
            req_r     <= q_req;
            is_done_r <= 1'b0;
            held_r    <= 1'b0;
            free_ok_r <= 1'b0;
          end
        end
        S_DSCN: begin
          if (hit) is_done_r <= 1'b1;
          if (didx_r != done_cnt_r) begin
            didx_r    <= didx_r + loa_pkg::DONE_CW'(1);
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
          end
          lidx_r <= '0;
        end
        S_LSCN: begin
          if (lidx_r != LIW'(loa_pkg::LANE_COUNT)) begin
            if (!busy_r[li]) begin
              free_ok_r   <= 1'b1;
              free_lane_r <= li;
            end else if (holder_r[li] == req_r.owner && !held_r) begin
              held_r      <= 1'b1;
              held_lane_r <= li;
            end
            lidx_r <= lidx_r + LIW'(1);
          end
        end
        S_UPD: begin
          res_r  <= upd_res;
          lidx_r <= '0;
          if (take_new) begin
            busy_r[free_lane_r]   <= 1'b1;
            holder_r[free_lane_r] <= req_r.owner;
            stamp_r[free_lane_r]  <= next_stamp_r;
            next_stamp_r          <= next_stamp_r + loa_pkg::STAMP_W'(1);
          end
          if (req_r.mode == loa_pkg::MODE_RELEASE) begin
            for (int i = 0; i < loa_pkg::LANE_COUNT; i++) begin
              if (busy_r[i] && holder_r[i] == req_r.owner) busy_r[i] <= 1'b0;
            end
          end
        end
        S_OLD: begin
          if (lidx_r != LIW'(loa_pkg::LANE_COUNT)) begin
            if (busy_r[li] && (!res_r.oldest_valid || stamp_r[li] < best_r)) begin
              best_r <= stamp_r[li];
            end
            res_r  <= old_res;
            lidx_r <= lidx_r + LIW'(1);
          end
        end
        S_OUT: begin
          if (!res_valid_r || res_ready) out_r <= res_r;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/loa_checker.sv
// ----------------------------------------------------------------------------
// loa_checker
// Port-level checks on the arbiter's result stream.
// ----------------------------------------------------------------------------
module loa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [1:0] out_tuser,
  input logic [7:0] out_tdata
);

  // output word held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no lane reported without lane_found
  a_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[1:0] == 2'd0)
    else $error("lane without lane_found");

  // probe always carries a lane and leaves a lane assigned
  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == loa_pkg::ST_PROBE |-> out_tdata[2] && out_tdata[5])
    else $error("probe without lane");

  // skip and busy never carry a lane
  a_nolane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == loa_pkg::ST_SKIP || out_tuser == loa_pkg::ST_BUSY)
    |-> !out_tdata[2])
    else $error("skip or busy with lane");

endmodule

bind lane_owner_arbiter_core loa_checker u_loa_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tuser, .out_tdata
);

// File: tb/loa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// loa_scoreboard
// Watches the request and result streams of the lane owner arbiter, models
// lane ownership and the processed store, and compares every result word.
// ----------------------------------------------------------------------------
module loa_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_data,
  output int          errors,
  output int          pending
);

  logic                               pass_mode;
  logic [loa_pkg::LANE_COUNT-1:0]     busy_q;
  logic [loa_pkg::OWNER_W-1:0]        holder_q [loa_pkg::LANE_COUNT];
  logic [loa_pkg::STAMP_W-1:0]        stamp_q  [loa_pkg::LANE_COUNT];
  logic [loa_pkg::STAMP_W-1:0]        stamp_next;
  logic [loa_pkg::OWNER_W-1:0]        done_q   [loa_pkg::DONE_DEPTH];
  int                                 done_n;
  loa_pkg::res_t                      want_q [$];

  function automatic bit owner_done(logic [loa_pkg::OWNER_W-1:0] who);
    for (int i = 0; i < done_n; i++)
      if (done_q[i] == who) return 1'b1;
    return 1'b0;
  endfunction

  // 0 none free, 1 already held, 2 newly taken
  function automatic int grab_lane(logic [loa_pkg::OWNER_W-1:0] who, output int lane);
    int free_idx;
    free_idx = -1;
    lane = 0;
    for (int i = 0; i < loa_pkg::LANE_COUNT; i++) begin
      if (!busy_q[i]) begin
        free_idx = i;
      end else if (holder_q[i] == who) begin
        lane = i;
        return 1;
      end
    end
    if (free_idx < 0) return 0;
    busy_q[free_idx]   = 1'b1;
    holder_q[free_idx] = who;
    stamp_q[free_idx]  = stamp_next;
    stamp_next         = stamp_next + loa_pkg::STAMP_W'(1);
    lane = free_idx;
    return 2;
  endfunction

  function automatic loa_pkg::res_t arbitrate(logic [1:0] mode,
                                              logic [loa_pkg::OWNER_W-1:0] who);
    loa_pkg::res_t r;
    int lane, k;
    logic [loa_pkg::STAMP_W-1:0] best;
    r = '0;
    if (mode == loa_pkg::MODE_TRY || mode == loa_pkg::MODE_MUST) begin
      if (mode == loa_pkg::MODE_TRY && pass_mode) begin
        r.status = loa_pkg::ST_IO;
      end else if (mode == loa_pkg::MODE_TRY && owner_done(who)) begin
        r.status = loa_pkg::ST_SKIP;
      end else begin
        k = grab_lane(who, lane);
        if (k == 0) begin
          r.status = loa_pkg::ST_BUSY;
        end else begin
          r.status     = (k == 2 && mode == loa_pkg::MODE_TRY) ?
                         loa_pkg::ST_PROBE : loa_pkg::ST_IO;
          r.lane       = lane[1:0];
          r.lane_found = 1'b1;
        end
      end
    end else begin
      if (!owner_done(who)) begin
        if (done_n >= loa_pkg::DONE_DEPTH) begin
          r.processed_full = 1'b1;
        end else begin
          done_q[done_n] = who;
          done_n++;
        end
      end
      if (mode == loa_pkg::MODE_RELEASE)
        for (int i = 0; i < loa_pkg::LANE_COUNT; i++)
          if (busy_q[i] && holder_q[i] == who) busy_q[i] = 1'b0;
    end
    best = '0;
    for (int i = 0; i < loa_pkg::LANE_COUNT; i++)
      if (busy_q[i] && (!r.oldest_valid || stamp_q[i] < best)) begin
        best = stamp_q[i];
        r.oldest_lane  = i[1:0];
        r.oldest_valid = 1'b1;
      end
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    loa_pkg::res_t got, exp_r;
    if (!rst_n) begin
      pass_mode  <= 1'b0;
      busy_q     = '0;
      stamp_next = '0;
      done_n     = 0;
      errors     <= 0;
      want_q.delete();
    end else begin
      if (cfg_we) pass_mode <= cfg_wdata;
      if (in_valid && in_ready)
        want_q.push_back(arbitrate(in_mode, in_data[loa_pkg::OWNER_W-1:0]));
      if (out_valid && out_ready) begin
        got = {out_status, out_data[1:0], out_data[2], out_data[4:3],
               out_data[5], out_data[6]};
        if (want_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch exp st=%0d ln=%0d f=%0d ol=%0d ov=%0d pf=%0d",
                     $time, exp_r.status, exp_r.lane, exp_r.lane_found,
                     exp_r.oldest_lane, exp_r.oldest_valid, exp_r.processed_full);
            $display("%0t:          got st=%0d ln=%0d f=%0d ol=%0d ov=%0d pf=%0d",
                     $time, got.status, got.lane, got.lane_found,
                     got.oldest_lane, got.oldest_valid, got.processed_full);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= want_q.size();
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the lane owner arbiter: directed corner cases, then random
// lane traffic over a small owner pool with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [63:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_data;
  int          errors, pending;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;
  logic [loa_pkg::OWNER_W-1:0] pool [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lane_owner_arbiter_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_valid), .in_tready(in_ready),
    .in_tuser(in_mode), .in_tdata(in_data),
    .out_tvalid(out_valid), .out_tready(out_ready),
    .out_tuser(out_status), .out_tdata(out_data)
  );

  loa_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // send one request word after an optional random gap; valid stays up for the next one
  task automatic send_word(logic [1:0] mode, logic [loa_pkg::OWNER_W-1:0] who,
                           bit gap = 1);
    int n;
    n = gap ? $urandom_range(0, 14) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_data  <= {1'b0, who};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected word
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic drain_then_cfg(logic val);
    drain();
    repeat (40) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [loa_pkg::OWNER_W-1:0] rand_owner();
    return loa_pkg::OWNER_W'({$urandom(), $urandom()});
  endfunction

  // result side: random stall per word, with some stall-free stretches
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int m, k;
    for (int i = 0; i < 16; i++) pool[i] = rand_owner();
    pool[0] = '0;
    pool[1] = {loa_pkg::OWNER_W{1'b1}};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fill lanes, hit busy, re-acquire, double hold, release, skip
    for (int i = 0; i < 4; i++) send_word(loa_pkg::MODE_TRY, pool[i]);
    send_word(loa_pkg::MODE_TRY, pool[4]);
    send_word(loa_pkg::MODE_MUST, pool[5]);
    send_word(loa_pkg::MODE_TRY, pool[2]);
    send_word(loa_pkg::MODE_MUST, pool[3]);
    send_word(loa_pkg::MODE_RELEASE, pool[1]);
    send_word(loa_pkg::MODE_MUST, pool[0]);
    send_word(loa_pkg::MODE_TRY, pool[1]);
    send_word(loa_pkg::MODE_MUST, pool[1]);
    send_word(loa_pkg::MODE_MARK, pool[2]);
    send_word(loa_pkg::MODE_TRY, pool[2]);
    send_word(loa_pkg::MODE_RELEASE, pool[0]);
    send_word(loa_pkg::MODE_RELEASE, pool[0]);
    for (int i = 0; i < 4; i++) send_word(loa_pkg::MODE_RELEASE, pool[i]);
    // passthrough on
    drain_then_cfg(1'b1);
    send_word(loa_pkg::MODE_TRY, pool[6]);
    send_word(loa_pkg::MODE_MUST, pool[7]);
    send_word(loa_pkg::MODE_TRY, pool[7]);
    drain_then_cfg(1'b0);

    // random: mostly pool owners; fill the processed store late in the run
    for (int it = 0; it < 1000; it++) begin
      if (it == 500) begin
        drain();
        drain_then_cfg($urandom_range(0, 1) != 0);
      end
      if (it == 700) drain_then_cfg(1'b0);
      m = $urandom_range(0, 3);
      k = $urandom_range(0, 15);
      if (it >= 600 && it < 680)
        send_word(loa_pkg::MODE_MARK, rand_owner(), $urandom_range(0, 1) != 0);
      else if ($urandom_range(0, 9) == 0) send_word(m[1:0], rand_owner());
      else send_word(m[1:0], pool[k], $urandom_range(0, 2) != 0);
    end

    drain();
    stim_done = 1'b1;
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule
